// File: rtl/display_timing_descriptor_decoder_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the display timing descriptor decoder
// Implication forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef DISPLAY_TIMING_DESCRIPTOR_DECODER_ASSERT_SVH
`define DISPLAY_TIMING_DESCRIPTOR_DECODER_ASSERT_SVH

// same-cycle implication
`define DTD_ASSERT_IMP(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("display timing decoder check failed");

// next-cycle implication
`define DTD_ASSERT_NXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("display timing decoder check failed");

`endif

// File: rtl/dtd_pkg.sv
// ----------------------------------------------------------------------------
// dtd_pkg
// Types and constants shared by the display timing decoder pipeline.
// ----------------------------------------------------------------------------
package dtd_pkg;

  localparam int NUM_W     = 36;
  localparam int DEN_W     = 26;
  localparam int DIV_STEPS = NUM_W;
  // decode, multiply, divider steps, output register
  localparam int LATENCY   = DIV_STEPS + 3;

  localparam logic [19:0] CLK_SCALE     = 20'd1000000;
  localparam logic [7:0]  STD_UNUSED    = 8'h01;
  localparam logic [7:0]  STD_RESERVED  = 8'h00;
  localparam logic [6:0]  STD_HZ_OFFSET = 7'd60;
  localparam logic [6:0]  STD_HZ_SCALE  = 7'd100;
  localparam logic [8:0]  STD_H_OFFSET  = 9'd31;

  localparam logic [1:0] ASPECT_16_10 = 2'd0;
  localparam logic [1:0] ASPECT_4_3   = 2'd1;
  localparam logic [1:0] ASPECT_5_4   = 2'd2;
  localparam logic [1:0] ASPECT_16_9  = 2'd3;

  typedef struct packed {
    logic [11:0] h_active;
    logic [11:0] v_active;
    logic [11:0] h_blank;
    logic [11:0] v_blank;
    logic [15:0] pixel_clock;
    logic [13:0] std_rate;
    logic        is_std;
    logic        rate_valid;
    logic        entry_used;
    logic        native;
  } side_t;

  typedef struct packed {
    logic [12:0] h_total;
    logic [12:0] v_total;
    side_t       side;
  } dec_t;

  typedef struct packed {
    logic [DEN_W-1:0] rem;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
    side_t            side;
  } div_t;

endpackage

// File: rtl/display_timing_descriptor_decoder.sv
// ----------------------------------------------------------------------------
// display_timing_descriptor_decoder
// Decodes EDID detailed and standard timing records into sizes and refresh.
// ----------------------------------------------------------------------------
// One record is taken every clock cycle; busy never rises. Each record gives
// one result, shown with done for a single cycle once it has passed through
// one decode stage, one multiply stage, a 36-stage divider that forms the
// refresh rate one quotient bit per stage, and the output register.
// Results leave in the order records arrived and must be captured when done
// is high.
// ----------------------------------------------------------------------------
module display_timing_descriptor_decoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        op,
  input  logic        is_native,
  input  logic [7:0]  byte0,
  input  logic [7:0]  byte1,
  input  logic [7:0]  byte2,
  input  logic [7:0]  byte3,
  input  logic [7:0]  byte4,
  input  logic [7:0]  byte5,
  input  logic [7:0]  byte6,
  input  logic [7:0]  byte7,
  output logic        done,
  output logic [11:0] h_active,
  output logic [11:0] v_active,
  output logic [11:0] h_blank,
  output logic [11:0] v_blank,
  output logic [15:0] pixel_clock,
  output logic [35:0] refresh_centihz,
  output logic        rate_valid,
  output logic        entry_used,
  output logic        native_out
);

  logic          dec_valid, mul_valid, div_valid;
  dtd_pkg::dec_t dec;
  dtd_pkg::div_t mul, div;
  logic [35:0]   refresh_next;

  assign busy = 1'b0;

  dtd_decode u_decode (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (start && !busy),
    .op        (op),
    .is_native (is_native),
    .byte0     (byte0),
    .byte1     (byte1),
    .byte2     (byte2),
    .byte3     (byte3),
    .byte4     (byte4),
    .byte5     (byte5),
    .byte6     (byte6),
    .byte7     (byte7),
    .out_valid (dec_valid),
    .out       (dec)
  );

  dtd_mult u_mult (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (dec_valid),
    .in        (dec),
    .out_valid (mul_valid),
    .out       (mul)
  );

  dtd_divider u_divider (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (mul_valid),
    .in        (mul),
    .out_valid (div_valid),
    .out       (div)
  );

  always_comb begin
    priority if (div.side.is_std) begin
      refresh_next = 36'(div.side.std_rate);
    end else if (div.side.rate_valid) begin
      refresh_next = div.num;
    end else begin
      refresh_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= div_valid;
    end
    h_active        <= div.side.h_active;
    v_active        <= div.side.v_active;
    h_blank         <= div.side.h_blank;
    v_blank         <= div.side.v_blank;
    pixel_clock     <= div.side.pixel_clock;
    refresh_centihz <= refresh_next;
    rate_valid      <= div.side.rate_valid;
    entry_used      <= div.side.entry_used;
    native_out      <= div.side.native;
  end

endmodule

// File: rtl/dtd_decode.sv
// ----------------------------------------------------------------------------
// dtd_decode
// First stage: unpack record bytes into sizes, totals and standard timing.
// ----------------------------------------------------------------------------
module dtd_decode (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic          op,
  input  logic          is_native,
  input  logic [7:0]    byte0,
  input  logic [7:0]    byte1,
  input  logic [7:0]    byte2,
  input  logic [7:0]    byte3,
  input  logic [7:0]    byte4,
  input  logic [7:0]    byte5,
  input  logic [7:0]    byte6,
  input  logic [7:0]    byte7,
  output logic          out_valid,
  output dtd_pkg::dec_t out
);

  logic [11:0] ha, hb, va, vb;
  logic [11:0] hres, vres;
  logic [8:0]  hcode;
  logic [15:0] h_x5, h_x3, h_x9;
  logic [13:0] h_x4;
  logic [29:0] h_div5;
  logic [6:0]  hz;
  logic [13:0] std_rate;
  logic        unused;
  dtd_pkg::dec_t dec_next;

  assign ha = {byte4[7:4], byte2};
  assign hb = {byte4[3:0], byte3};
  assign va = {byte7[7:4], byte5};
  assign vb = {byte7[3:0], byte6};

  assign unused   = (byte0 == dtd_pkg::STD_UNUSED) && (byte1 == dtd_pkg::STD_UNUSED);
  assign hcode    = {1'b0, byte0} + dtd_pkg::STD_H_OFFSET;
  assign hres     = (byte0 == dtd_pkg::STD_RESERVED) ? 12'd0 : {hcode, 3'b000};
  assign h_x5     = {2'b00, hres, 2'b00} + {4'b0000, hres};
  assign h_x3     = {3'b000, hres, 1'b0} + {4'b0000, hres};
  assign h_x9     = {1'b0, hres, 3'b000} + {4'b0000, hres};
  assign h_x4     = {hres, 2'b00};
  // divide by five through the reciprocal, exact below 2^14
  assign h_div5   = 30'(h_x4) * 30'd52429;
  assign hz       = {1'b0, byte1[5:0]} + dtd_pkg::STD_HZ_OFFSET;
  assign std_rate = 14'(hz) * 14'(dtd_pkg::STD_HZ_SCALE);

  always_comb begin
    unique case (byte1[7:6])
      dtd_pkg::ASPECT_16_10: vres = h_x5[14:3];
      dtd_pkg::ASPECT_4_3:   vres = h_x3[13:2];
      dtd_pkg::ASPECT_5_4:   vres = h_div5[29:18];
      dtd_pkg::ASPECT_16_9:  vres = h_x9[15:4];
      default:               vres = 12'd0;
    endcase
  end

  always_comb begin
    dec_next = '0;
    dec_next.side.native = is_native;
    if (!op) begin
      dec_next.h_total          = {1'b0, ha} + {1'b0, hb};
      dec_next.v_total          = {1'b0, va} + {1'b0, vb};
      dec_next.side.h_active    = ha;
      dec_next.side.v_active    = va;
      dec_next.side.h_blank     = hb;
      dec_next.side.v_blank     = vb;
      dec_next.side.pixel_clock = {byte1, byte0};
      dec_next.side.entry_used  = 1'b1;
      dec_next.side.rate_valid  = (dec_next.h_total != '0) && (dec_next.v_total != '0);
    end else begin
      dec_next.side.is_std = 1'b1;
      if (!unused) begin
        dec_next.side.h_active   = hres;
        dec_next.side.v_active   = vres;
        dec_next.side.std_rate   = std_rate;
        dec_next.side.rate_valid = 1'b1;
        dec_next.side.entry_used = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
    out <= dec_next;
  end

endmodule

// File: rtl/dtd_mult.sv
// ----------------------------------------------------------------------------
// dtd_mult
// Second stage: scale the pixel clock and form the total frame area.
// ----------------------------------------------------------------------------
module dtd_mult (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  dtd_pkg::dec_t in,
  output logic          out_valid,
  output dtd_pkg::div_t out
);

  logic [dtd_pkg::DEN_W-1:0] area;
  logic [dtd_pkg::NUM_W-1:0] scaled;

  assign area   = dtd_pkg::DEN_W'(in.h_total) * dtd_pkg::DEN_W'(in.v_total);
  assign scaled = dtd_pkg::NUM_W'(in.side.pixel_clock) * dtd_pkg::NUM_W'(dtd_pkg::CLK_SCALE);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
    out.rem  <= '0;
    out.num  <= scaled;
    out.den  <= area;
    out.side <= in.side;
  end

endmodule

// File: rtl/dtd_divider.sv
// ----------------------------------------------------------------------------
// dtd_divider
// Restoring divider, one quotient bit per register stage.
// ----------------------------------------------------------------------------
module dtd_divider (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  dtd_pkg::div_t in,
  output logic          out_valid,
  output dtd_pkg::div_t out
);

  logic          [dtd_pkg::DIV_STEPS-1:0] vld;
  dtd_pkg::div_t                          stg  [dtd_pkg::DIV_STEPS];
  dtd_pkg::div_t                          prev [dtd_pkg::DIV_STEPS];
  dtd_pkg::div_t                          step [dtd_pkg::DIV_STEPS];

  for (genvar i = 0; i < dtd_pkg::DIV_STEPS; i++) begin : g_step
    logic                        vld_in;
    logic [dtd_pkg::DEN_W:0]     shifted;
    logic [dtd_pkg::DEN_W:0]     diff;
    logic                        ge;

    if (i == 0) begin : g_first
      assign prev[i] = in;
      assign vld_in  = in_valid;
    end else begin : g_rest
      assign prev[i] = stg[i-1];
      assign vld_in  = vld[i-1];
    end

    assign shifted = {prev[i].rem, prev[i].num[dtd_pkg::NUM_W-1]};
    assign ge      = shifted >= {1'b0, prev[i].den};
    assign diff    = shifted - {1'b0, prev[i].den};

    always_comb begin
      step[i]      = prev[i];
      step[i].rem  = ge ? diff[dtd_pkg::DEN_W-1:0] : shifted[dtd_pkg::DEN_W-1:0];
      step[i].num  = {prev[i].num[dtd_pkg::NUM_W-2:0], ge};
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i] <= 1'b0;
      end else begin
        vld[i] <= vld_in;
      end
      stg[i] <= step[i];
    end
  end

  assign out_valid = vld[dtd_pkg::DIV_STEPS-1];
  assign out       = stg[dtd_pkg::DIV_STEPS-1];

endmodule

// File: rtl/dtd_checker.sv
// ----------------------------------------------------------------------------
// dtd_checker
// Port-level checks on the display timing decoder, bound to the top level.
// ----------------------------------------------------------------------------
`include "display_timing_descriptor_decoder_assert.svh"

module dtd_checker (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        op,
  input logic [7:0]  byte0,
  input logic [7:0]  byte1,
  input logic        done,
  input logic [11:0] h_active,
  input logic [15:0] pixel_clock,
  input logic [35:0] refresh_centihz,
  input logic        rate_valid,
  input logic        entry_used
);

  `DTD_ASSERT_IMP(a_beat_returns, clk, rst, start && !busy, ##(dtd_pkg::LATENCY) done)
  `DTD_ASSERT_IMP(a_no_rate_zero, clk, rst, done && !rate_valid, refresh_centihz == 36'd0)
  `DTD_ASSERT_IMP(a_unused_empty, clk, rst, done && !entry_used,
                  !rate_valid && h_active == 12'd0 && pixel_clock == 16'd0)
  `DTD_ASSERT_NXT(a_unused_marked, clk, rst,
                  start && !busy && op && byte0 == dtd_pkg::STD_UNUSED
                    && byte1 == dtd_pkg::STD_UNUSED,
                  ##(dtd_pkg::LATENCY - 1) (done && !entry_used))

endmodule

bind display_timing_descriptor_decoder dtd_checker u_dtd_checker (.*);

// File: tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// display_timing_descriptor_decoder testbench
// Drives detailed and standard timing records in random bursts: first a
// directed table, then random records. Each result is compared field by
// field, in order, with the value typed into the table or with the value
// worked out by an in-bench decoder.
// ----------------------------------------------------------------------------
module testbench;

  localparam int RANDOM_RECORDS = 1830;
  localparam int PRESSURE_AT    = 900;
  localparam int IDLE_LIMIT     = 2000;

  typedef enum logic { OP_DETAILED = 1'b0, OP_STANDARD = 1'b1 } op_e;

  // bytes[0] is byte0, so hex literals read byte7 first
  typedef struct packed {
    op_e             op;
    logic            native;
    logic [7:0][7:0] bytes;
  } record_t;

  typedef struct packed {
    logic [11:0] h_active;
    logic [11:0] v_active;
    logic [11:0] h_blank;
    logic [11:0] v_blank;
    logic [15:0] pixel_clock;
    logic [35:0] refresh;
    logic        rate_valid;
    logic        entry_used;
    logic        native;
  } timing_t;

  typedef struct packed {
    record_t rec;
    logic    typed;
    timing_t want;
  } row_t;

  localparam row_t DIRECTED_ROWS [22] = '{
    '{'{OP_DETAILED, 1'b0, 64'h0000_0000_0000_0000}, 1'b1,
      '{12'd0, 12'd0, 12'd0, 12'd0, 16'd0, 36'd0, 1'b0, 1'b1, 1'b0}},
    '{'{OP_DETAILED, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF}, 1'b1,
      '{12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 16'hFFFF, 36'd977, 1'b1, 1'b1, 1'b1}},
    '{'{OP_DETAILED, 1'b0, 64'h0000_0100_0001_FFFF}, 1'b1,
      '{12'd1, 12'd1, 12'd0, 12'd0, 16'hFFFF, 36'd65535000000, 1'b1, 1'b1, 1'b0}},
    '{'{OP_DETAILED, 1'b1, 64'h0000_0A00_0000_1234}, 1'b1,
      '{12'd0, 12'd10, 12'd0, 12'd0, 16'h1234, 36'd0, 1'b0, 1'b1, 1'b1}},
    '{'{OP_DETAILED, 1'b0, 64'h0000_0000_2080_5678}, 1'b1,
      '{12'h080, 12'd0, 12'h020, 12'd0, 16'h5678, 36'd0, 1'b0, 1'b1, 1'b0}},
    '{'{OP_DETAILED, 1'b1, 64'h402D_3871_1880_3A02}, 1'b0, timing_t'(0)},
    '{'{OP_DETAILED, 1'b0, 64'hF00F_00F0_FF00_0001}, 1'b0, timing_t'(0)},
    '{'{OP_DETAILED, 1'b1, 64'h1111_1111_1111_0000}, 1'b0, timing_t'(0)},
    '{'{OP_DETAILED, 1'b0, 64'hFFFF_FFFF_FFFF_0001}, 1'b0, timing_t'(0)},
    '{'{OP_STANDARD, 1'b0, 64'h0000_0000_0000_0101}, 1'b1,
      '{12'd0, 12'd0, 12'd0, 12'd0, 16'd0, 36'd0, 1'b0, 1'b0, 1'b0}},
    '{'{OP_STANDARD, 1'b1, 64'hFFFF_FFFF_FFFF_0101}, 1'b1,
      '{12'd0, 12'd0, 12'd0, 12'd0, 16'd0, 36'd0, 1'b0, 1'b0, 1'b1}},
    '{'{OP_STANDARD, 1'b0, 64'h0000_0000_0000_0000}, 1'b1,
      '{12'd0, 12'd0, 12'd0, 12'd0, 16'd0, 36'd6000, 1'b1, 1'b1, 1'b0}},
    '{'{OP_STANDARD, 1'b1, 64'h0000_0000_0000_FF00}, 1'b1,
      '{12'd0, 12'd0, 12'd0, 12'd0, 16'd0, 36'd12300, 1'b1, 1'b1, 1'b1}},
    '{'{OP_STANDARD, 1'b0, 64'h0000_0000_0000_FFFF}, 1'b1,
      '{12'd2288, 12'd1287, 12'd0, 12'd0, 16'd0, 36'd12300, 1'b1, 1'b1, 1'b0}},
    '{'{OP_STANDARD, 1'b1, 64'h0000_0000_0000_0081}, 1'b0, timing_t'(0)},
    '{'{OP_STANDARD, 1'b0, 64'h0000_0000_0000_4F81}, 1'b0, timing_t'(0)},
    '{'{OP_STANDARD, 1'b1, 64'h0000_0000_0000_9581}, 1'b0, timing_t'(0)},
    '{'{OP_STANDARD, 1'b0, 64'h0000_0000_0000_C081}, 1'b0, timing_t'(0)},
    '{'{OP_STANDARD, 1'b1, 64'h0000_0000_0000_0001}, 1'b0, timing_t'(0)},
    '{'{OP_STANDARD, 1'b0, 64'h0000_0000_0000_0100}, 1'b0, timing_t'(0)},
    '{'{OP_STANDARD, 1'b1, 64'hA5A5_A5A5_5A5A_4101}, 1'b0, timing_t'(0)},
    '{'{OP_STANDARD, 1'b1, 64'h0000_0000_0000_3FFF}, 1'b0, timing_t'(0)}
  };

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        start     = 1'b0;
  logic        op        = 1'b0;
  logic        is_native = 1'b0;
  logic [7:0]  byte0     = 8'd0;
  logic [7:0]  byte1     = 8'd0;
  logic [7:0]  byte2     = 8'd0;
  logic [7:0]  byte3     = 8'd0;
  logic [7:0]  byte4     = 8'd0;
  logic [7:0]  byte5     = 8'd0;
  logic [7:0]  byte6     = 8'd0;
  logic [7:0]  byte7     = 8'd0;
  logic        busy;
  logic        done;
  logic [11:0] h_active;
  logic [11:0] v_active;
  logic [11:0] h_blank;
  logic [11:0] v_blank;
  logic [15:0] pixel_clock;
  logic [35:0] refresh_centihz;
  logic        rate_valid;
  logic        entry_used;
  logic        native_out;

  timing_t pending_timings[$];
  int      mismatches  = 0;
  int      idle_cycles = 0;
  int      burst_left  = 1;

  display_timing_descriptor_decoder u_top (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .busy            (busy),
    .op              (op),
    .is_native       (is_native),
    .byte0           (byte0),
    .byte1           (byte1),
    .byte2           (byte2),
    .byte3           (byte3),
    .byte4           (byte4),
    .byte5           (byte5),
    .byte6           (byte6),
    .byte7           (byte7),
    .done            (done),
    .h_active        (h_active),
    .v_active        (v_active),
    .h_blank         (h_blank),
    .v_blank         (v_blank),
    .pixel_clock     (pixel_clock),
    .refresh_centihz (refresh_centihz),
    .rate_valid      (rate_valid),
    .entry_used      (entry_used),
    .native_out      (native_out)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic timing_t decode_timing(input record_t r);
    timing_t     t;
    logic [63:0] ha;
    logic [63:0] hb;
    logic [63:0] va;
    logic [63:0] vb;
    logic [63:0] pclk;
    logic [63:0] area;
    logic [63:0] hres;
    logic [63:0] vres;
    t = '0;
    t.native = r.native;
    t.entry_used = 1'b1;
    if (r.op == OP_DETAILED) begin
      ha = 64'({r.bytes[4][7:4], r.bytes[2]});
      hb = 64'({r.bytes[4][3:0], r.bytes[3]});
      va = 64'({r.bytes[7][7:4], r.bytes[5]});
      vb = 64'({r.bytes[7][3:0], r.bytes[6]});
      pclk = 64'({r.bytes[1], r.bytes[0]});
      area = (ha + hb) * (va + vb);
      t.h_active = ha[11:0];
      t.h_blank = hb[11:0];
      t.v_active = va[11:0];
      t.v_blank = vb[11:0];
      t.pixel_clock = pclk[15:0];
      if (area != 0) begin
        t.refresh = 36'((pclk * 64'd1000000) / area);
        t.rate_valid = 1'b1;
      end
    end else if (r.bytes[0] == dtd_pkg::STD_UNUSED && r.bytes[1] == dtd_pkg::STD_UNUSED) begin
      t.entry_used = 1'b0;
    end else begin
      hres = (r.bytes[0] == dtd_pkg::STD_RESERVED) ? 64'd0
                                                   : (64'(r.bytes[0]) + 64'd31) * 64'd8;
      case (r.bytes[1][7:6])
        dtd_pkg::ASPECT_16_10: vres = hres * 64'd10 / 64'd16;
        dtd_pkg::ASPECT_4_3:   vres = hres * 64'd3 / 64'd4;
        dtd_pkg::ASPECT_5_4:   vres = hres * 64'd4 / 64'd5;
        default:               vres = hres * 64'd9 / 64'd16;
      endcase
      t.h_active = hres[11:0];
      t.v_active = vres[11:0];
      t.refresh = (36'(r.bytes[1][5:0]) + 36'd60) * 36'd100;
      t.rate_valid = 1'b1;
    end
    return t;
  endfunction

  function automatic record_t random_record();
    record_t r;
    int      pick;
    r.op = $urandom_range(0, 1) ? OP_STANDARD : OP_DETAILED;
    r.native = 1'($urandom_range(0, 1));
    r.bytes = {$urandom, $urandom};
    pick = $urandom_range(0, 15);
    if (r.op == OP_DETAILED) begin
      case (pick)
        0: begin
          r.bytes[2] = '0;
          r.bytes[3] = '0;
          r.bytes[4] = '0;
        end
        1: begin
          r.bytes[5] = '0;
          r.bytes[6] = '0;
          r.bytes[7] = '0;
        end
        2, 3: begin
          r.bytes[4] = '0;
          r.bytes[7] = '0;
        end
        default: ;
      endcase
    end else begin
      case (pick)
        0, 1: begin
          r.bytes[0] = dtd_pkg::STD_UNUSED;
          r.bytes[1] = dtd_pkg::STD_UNUSED;
        end
        2: r.bytes[0] = dtd_pkg::STD_RESERVED;
        3: r.bytes[0] = dtd_pkg::STD_UNUSED;
        4: r.bytes[1] = dtd_pkg::STD_UNUSED;
        default: ;
      endcase
    end
    return r;
  endfunction

  // hold start across a burst, drop it for a random gap at the end
  task automatic pace();
    burst_left--;
    if (burst_left == 0) begin
      @(negedge clk) start <= 1'b0;
      repeat ($urandom_range(0, 14)) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 24);
    end
  endtask

  task automatic send_record(input record_t r, input logic typed, input timing_t want);
    @(negedge clk);
    op        <= r.op;
    is_native <= r.native;
    byte0     <= r.bytes[0];
    byte1     <= r.bytes[1];
    byte2     <= r.bytes[2];
    byte3     <= r.bytes[3];
    byte4     <= r.bytes[4];
    byte5     <= r.bytes[5];
    byte6     <= r.bytes[6];
    byte7     <= r.bytes[7];
    start     <= 1'b1;
    while (busy) @(negedge clk);
    @(posedge clk);
    pending_timings.push_back(typed ? want : decode_timing(r));
    pace();
  endtask

  task automatic drain();
    @(negedge clk) start <= 1'b0;
    while (pending_timings.size() != 0) @(posedge clk);
    burst_left = 1;
  endtask

  task automatic compare_field(input string name, input logic [35:0] want,
                               input logic [35:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0d got %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk) rst <= 1'b0;
    foreach (DIRECTED_ROWS[i]) begin
      send_record(DIRECTED_ROWS[i].rec, DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].want);
    end
    drain();
    for (int i = 0; i < RANDOM_RECORDS; i++) begin
      if (i == PRESSURE_AT) drain();
      send_record(random_record(), 1'b0, timing_t'(0));
    end
    drain();
    repeat (dtd_pkg::LATENCY + 8) @(posedge clk);
    if (mismatches == 0) begin
      $display("** display_timing_descriptor_decoder: PASSED **");
    end else begin
      $display("** display_timing_descriptor_decoder: FAILED **");
    end
    $finish;
  end

  always @(posedge clk) begin
    timing_t want;
    if (!rst && done) begin
      if (pending_timings.size() == 0) begin
        $display("%0t: result beat with nothing expected", $time);
        mismatches++;
      end else begin
        want = pending_timings.pop_front();
        compare_field("h_active", 36'(want.h_active), 36'(h_active));
        compare_field("v_active", 36'(want.v_active), 36'(v_active));
        compare_field("h_blank", 36'(want.h_blank), 36'(h_blank));
        compare_field("v_blank", 36'(want.v_blank), 36'(v_blank));
        compare_field("pixel_clock", 36'(want.pixel_clock), 36'(pixel_clock));
        compare_field("refresh_centihz", want.refresh, refresh_centihz);
        compare_field("rate_valid", 36'(want.rate_valid), 36'(rate_valid));
        compare_field("entry_used", 36'(want.entry_used), 36'(entry_used));
        compare_field("native_out", 36'(want.native), 36'(native_out));
      end
    end
  end

  always @(posedge clk) begin
    if ((start && !busy) || done) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IDLE_LIMIT) begin
      $display("%0t: no beat for %0d cycles", $time, IDLE_LIMIT);
      $display("** display_timing_descriptor_decoder: FAILED **");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
